// File: sv/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg
// Types and constants shared by the midpoint line rasterizer and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mlr_pkg;

    // Coordinate width of every endpoint and pixel.
    localparam int COORD_BITS = 12;

    // Width of the decision variable: it spans -2*major .. 2*minor.
    localparam int DEC_BITS = COORD_BITS + 3;

    // Request operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // One input request.
    typedef struct packed {
        logic                         op;
        logic signed [COORD_BITS-1:0] x_start;
        logic signed [COORD_BITS-1:0] y_start;
        logic signed [COORD_BITS-1:0] x_end;
        logic signed [COORD_BITS-1:0] y_end;
    } t_in_item;

    // One emitted pixel.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic                         last_pixel;
    } t_out_item;

endpackage

`default_nettype wire

// File: sv/midpoint_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_top
// Midpoint line rasterizer for all octants, one pixel per request.
// ----------------------------------------------------------------------------
// A start request loads two endpoints and yields the first pixel of the line,
// on the endpoint of smaller x (the second one if the x are equal); each step
// request after it yields the next pixel, and the pixel on the other endpoint
// carries last_pixel. A step while no line is active yields nothing. The line
// state registers feed one add and compare on the decision variable, whose
// result lands in a single output register, so requests may arrive in every
// cycle. o_ready drops only while it holds a pixel the sink has not taken.
`default_nettype none

module midpoint_line_rasterizer_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire mlr_pkg::t_in_item i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output mlr_pkg::t_out_item     o_data
);
    import mlr_pkg::*;

    // Line state.
    logic                         r_active,   n_active;
    logic                         r_ymajor,   n_ymajor;
    logic                         r_down,     n_down;
    logic signed [COORD_BITS-1:0] r_cur_x,    n_cur_x;
    logic signed [COORD_BITS-1:0] r_cur_y,    n_cur_y;
    logic signed [COORD_BITS-1:0] r_stop,     n_stop;
    logic        [COORD_BITS-1:0] r_major,    n_major;
    logic        [COORD_BITS-1:0] r_minor,    n_minor;
    logic signed [DEC_BITS-1:0]   r_decision, n_decision;

    // Output register.
    logic      r_out_valid, n_out_valid;
    t_out_item r_out,       n_out;

    // Setup terms for a start request.
    logic                         s_swap;
    logic signed [COORD_BITS-1:0] s_x0, s_y0, s_x1, s_y1;
    logic signed [COORD_BITS:0]   s_dx, s_dy;
    logic        [COORD_BITS-1:0] s_adx, s_ady;
    logic                         s_down, s_ymajor;
    logic        [COORD_BITS-1:0] s_major, s_minor;

    // Step terms.
    logic                         t_minor_step;
    logic signed [DEC_BITS-1:0]   t_two_minor, t_two_major, t_inc;
    logic signed [COORD_BITS-1:0] t_ydir;
    logic signed [COORD_BITS-1:0] t_nx, t_ny;
    logic                         t_last;

    logic accept;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Order the endpoints by x and pick the major axis.
    always_comb begin
        s_swap = !(i_data.x_start < i_data.x_end);
        s_x0   = s_swap ? i_data.x_end   : i_data.x_start;
        s_y0   = s_swap ? i_data.y_end   : i_data.y_start;
        s_x1   = s_swap ? i_data.x_start : i_data.x_end;
        s_y1   = s_swap ? i_data.y_start : i_data.y_end;
        s_dx   = {s_x1[COORD_BITS-1], s_x1} - {s_x0[COORD_BITS-1], s_x0};
        s_dy   = {s_y1[COORD_BITS-1], s_y1} - {s_y0[COORD_BITS-1], s_y0};
        s_down = s_dy[COORD_BITS];
        s_adx  = s_dx[COORD_BITS-1:0];
        s_ady  = s_down ? COORD_BITS'(-s_dy) : s_dy[COORD_BITS-1:0];
        s_ymajor = (s_ady > s_adx) || ((s_ady == s_adx) && !s_down);
        s_major  = s_ymajor ? s_ady : s_adx;
        s_minor  = s_ymajor ? s_adx : s_ady;
    end

    // Advance one pixel from the stored state.
    always_comb begin
        t_minor_step = r_decision > 0;
        t_two_minor  = $signed({2'b00, r_minor, 1'b0});
        t_two_major  = $signed({2'b00, r_major, 1'b0});
        t_inc        = t_minor_step ? (t_two_minor - t_two_major) : t_two_minor;
        t_ydir       = r_down ? -COORD_BITS'(1) : COORD_BITS'(1);
        if (r_ymajor) begin
            t_ny   = r_cur_y + t_ydir;
            t_nx   = t_minor_step ? r_cur_x + COORD_BITS'(1) : r_cur_x;
            t_last = t_ny == r_stop;
        end else begin
            t_nx   = r_cur_x + COORD_BITS'(1);
            t_ny   = t_minor_step ? r_cur_y + t_ydir : r_cur_y;
            t_last = t_nx == r_stop;
        end
    end

    // Next state and output selection.
    always_comb begin
        n_active    = r_active;
        n_ymajor    = r_ymajor;
        n_down      = r_down;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_stop      = r_stop;
        n_major     = r_major;
        n_minor     = r_minor;
        n_decision  = r_decision;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;

        if (accept) begin
            if (i_data.op == OP_START) begin
                n_ymajor    = s_ymajor;
                n_down      = s_down;
                n_cur_x     = s_x0;
                n_cur_y     = s_y0;
                n_stop      = s_ymajor ? s_y1 : s_x1;
                n_major     = s_major;
                n_minor     = s_minor;
                n_decision  = $signed({2'b00, s_minor, 1'b0})
                            - $signed({3'b000, s_major});
                n_active    = (s_adx != '0) || (s_ady != '0);
                n_out       = '{pixel_x: s_x0, pixel_y: s_y0, last_pixel: !n_active};
                n_out_valid = 1'b1;
            end else if (r_active) begin
                n_cur_x     = t_nx;
                n_cur_y     = t_ny;
                n_decision  = r_decision + t_inc;
                n_active    = !t_last;
                n_out       = '{pixel_x: t_nx, pixel_y: t_ny, last_pixel: t_last};
                n_out_valid = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    // Line and pixel payload.
    always_ff @(posedge i_clk) begin
        r_ymajor   <= n_ymajor;
        r_down     <= n_down;
        r_cur_x    <= n_cur_x;
        r_cur_y    <= n_cur_y;
        r_stop     <= n_stop;
        r_major    <= n_major;
        r_minor    <= n_minor;
        r_decision <= n_decision;
        r_out      <= n_out;
    end

endmodule

`default_nettype wire

// File: sv/mlr_checker.sv
// ----------------------------------------------------------------------------
// mlr_checker
// Port-level checks on the midpoint line rasterizer, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mlr_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_ready,
    input wire mlr_pkg::t_in_item i_data,
    input wire logic              o_valid,
    input wire logic              i_ready,
    input wire mlr_pkg::t_out_item o_data
);
    import mlr_pkg::*;

    // A pixel that is not taken stays unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("pixel changed while stalled");

    // An empty output register never blocks requests.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("request blocked with empty output");

    // Reset leaves no pixel pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("pixel pending after reset");

    // Every start request yields a pixel in the next cycle.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_data.op == OP_START |=> o_valid)
        else $error("start request gave no pixel");

    // A one-point line yields that point as its final pixel.
    a_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_data.op == OP_START
        && i_data.x_start == i_data.x_end && i_data.y_start == i_data.y_end
        |=> o_data.last_pixel && o_data.pixel_x == $past(i_data.x_start)
        && o_data.pixel_y == $past(i_data.y_start))
        else $error("one-point line drawn wrongly");

endmodule

bind midpoint_line_rasterizer_top mlr_checker u_mlr_checker (.*);

`default_nettype wire
